// ===== src/assert_macros.svh =====
// Assertion helpers for the SHA-256 hasher. Clock clk, reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/shabh_pkg.sv =====
`timescale 1ns / 1ps

package shabh_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned HASH_WORDS  = 8;
	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned ROUND_W     = $clog2(ROUNDS);
	localparam int unsigned POS_W       = $clog2(BLOCK_WORDS);
	localparam int unsigned OUT_CNT_W   = $clog2(HASH_WORDS + 1);
	localparam int unsigned LEN_SHIFT   = 9; // 512 bits per block

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t PAD_HEAD = 32'h8000_0000;

	// Controller to datapath commands
	typedef struct packed {
		logic               load_word;   // shift request word into block window
		logic               load_pad;    // fill block window with the padding block
		logic               init_vars;   // copy chaining value into working variables
		logic               round;       // run one compression round
		logic               add;         // fold working variables into chaining value
		logic               count_block; // bump the block count
		logic               emit_digest; // load chaining value into output buffer
		logic               emit_error;  // load one error result into output buffer
		logic               restart;     // back to initial hash values
		logic [ROUND_W-1:0] round_idx;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	function automatic word_t iv_word(input logic [2:0] idx);
		word_t r;
		unique case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t round_const(input logic [ROUND_W-1:0] idx);
		word_t r;
		unique case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/shabh_ctrl.sv =====
`timescale 1ns / 1ps

module shabh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic              s_axis_tlast,
	input  shabh_pkg::status_t status,
	output shabh_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ROUND  = 6'b000010,
		S_ADD    = 6'b000100,
		S_PAD    = 6'b001000,
		S_FINISH = 6'b010000,
		S_ERROR  = 6'b100000
	} state_t;

	state_t                             state_q, state_d;
	logic [shabh_pkg::POS_W-1:0]        pos_q, pos_d;
	logic [shabh_pkg::ROUND_W-1:0]      rnd_q, rnd_d;
	logic                               last_q, last_d;
	logic                               pad_q, pad_d;
	logic                               accept;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d       = state_q;
		pos_d         = pos_q;
		rnd_d         = rnd_q;
		last_d        = last_q;
		pad_d         = pad_q;
		cmd           = '0;
		cmd.round_idx = rnd_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_word = 1'b1;
					// a last request always restarts the word count
					pos_d = s_axis_tlast ? '0 : pos_q + 1'b1;
					if (pos_q == shabh_pkg::POS_W'(shabh_pkg::BLOCK_WORDS - 1)) begin
						cmd.init_vars = 1'b1;
						last_d        = s_axis_tlast;
						pad_d         = 1'b0;
						state_d       = S_ROUND;
					end else if (s_axis_tlast) begin
						state_d = S_ERROR;
					end
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 1'b1;
				if (rnd_q == shabh_pkg::ROUND_W'(shabh_pkg::ROUNDS - 1)) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add         = 1'b1;
				cmd.count_block = !pad_q;
				priority if (pad_q) begin
					state_d = S_FINISH;
				end else if (last_q) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PAD: begin
				cmd.load_pad  = 1'b1;
				cmd.init_vars = 1'b1;
				pad_d         = 1'b1;
				state_d       = S_ROUND;
			end
			S_FINISH: begin
				if (!status.out_busy) begin
					cmd.emit_digest = 1'b1;
					cmd.restart     = 1'b1;
					last_d          = 1'b0;
					pad_d           = 1'b0;
					state_d         = S_IDLE;
				end
			end
			S_ERROR: begin
				if (!status.out_busy) begin
					cmd.emit_error = 1'b1;
					cmd.restart    = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			rnd_q   <= '0;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			rnd_q   <= rnd_d;
			last_q  <= last_d;
			pad_q   <= pad_d;
		end
	end

endmodule

// ===== src/shabh_datapath.sv =====
`timescale 1ns / 1ps

module shabh_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  shabh_pkg::cmd_t     cmd,
	output shabh_pkg::status_t  status,
	input  shabh_pkg::word_t    s_axis_tdata,
	input  logic                m_axis_tready,
	output logic                m_axis_tvalid,
	output shabh_pkg::word_t    m_axis_tdata,
	output logic                m_axis_tlast,
	output logic                m_axis_tuser
);

	function automatic shabh_pkg::word_t rotr(input shabh_pkg::word_t x, input int n);
		return (x >> n) | (x << (shabh_pkg::WORD_W - n));
	endfunction

	shabh_pkg::word_t                   w_q   [shabh_pkg::BLOCK_WORDS];
	shabh_pkg::word_t                   v_q   [shabh_pkg::HASH_WORDS];
	shabh_pkg::word_t                   h_q   [shabh_pkg::HASH_WORDS];
	shabh_pkg::word_t                   obuf_q[shabh_pkg::HASH_WORDS];
	shabh_pkg::word_t                   blocks_q;
	logic [shabh_pkg::OUT_CNT_W-1:0]    out_left_q;
	logic                               out_err_q;

	shabh_pkg::word_t sig0, sig1, w_new;
	shabh_pkg::word_t big0, big1, ch, maj, t1, t2;
	logic [2*shabh_pkg::WORD_W-1:0] bit_len;
	logic out_take;

	// message schedule: oldest word sits at the head of the window
	always_comb begin
		sig0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		sig1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = sig1 + w_q[9] + sig0 + w_q[0];
	end

	always_comb begin
		big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + ch + shabh_pkg::round_const(cmd.round_idx) + w_q[0];
		big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
	end

	assign bit_len = {shabh_pkg::WORD_W'(0), blocks_q} << shabh_pkg::LEN_SHIFT;

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			for (int i = 0; i < shabh_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[shabh_pkg::BLOCK_WORDS-1] <= s_axis_tdata;
		end else if (cmd.load_pad) begin
			// zero the middle, then head marker and the 64-bit length at the tail
			for (int i = 1; i < shabh_pkg::BLOCK_WORDS - 2; i++) begin
				w_q[i] <= '0;
			end
			w_q[0]                        <= shabh_pkg::PAD_HEAD;
			w_q[shabh_pkg::BLOCK_WORDS-2] <= bit_len[2*shabh_pkg::WORD_W-1:shabh_pkg::WORD_W];
			w_q[shabh_pkg::BLOCK_WORDS-1] <= bit_len[shabh_pkg::WORD_W-1:0];
		end else if (cmd.round) begin
			for (int i = 0; i < shabh_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[shabh_pkg::BLOCK_WORDS-1] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_vars) begin
			for (int i = 0; i < shabh_pkg::HASH_WORDS; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < shabh_pkg::HASH_WORDS; i++) begin
				h_q[i] <= shabh_pkg::iv_word(3'(i));
			end
			blocks_q <= '0;
		end else if (cmd.restart) begin
			for (int i = 0; i < shabh_pkg::HASH_WORDS; i++) begin
				h_q[i] <= shabh_pkg::iv_word(3'(i));
			end
			blocks_q <= '0;
		end else if (cmd.add) begin
			for (int i = 0; i < shabh_pkg::HASH_WORDS; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
			if (cmd.count_block) begin
				blocks_q <= blocks_q + 1'b1;
			end
		end
	end

	// output buffer: drains one word per request, independent of the hashing side
	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (out_left_q != '0);
	assign m_axis_tdata  = obuf_q[0];
	assign m_axis_tlast  = (out_left_q == shabh_pkg::OUT_CNT_W'(1));
	assign m_axis_tuser  = out_err_q;
	assign status.out_busy = m_axis_tvalid;

	always_ff @(posedge clk) begin
		if (cmd.emit_digest) begin
			for (int i = 0; i < shabh_pkg::HASH_WORDS; i++) begin
				obuf_q[i] <= h_q[i];
			end
		end else if (cmd.emit_error) begin
			obuf_q[0] <= '0;
		end else if (out_take) begin
			for (int i = 0; i < shabh_pkg::HASH_WORDS - 1; i++) begin
				obuf_q[i] <= obuf_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_left_q <= '0;
			out_err_q  <= 1'b0;
		end else if (cmd.emit_digest) begin
			out_left_q <= shabh_pkg::OUT_CNT_W'(shabh_pkg::HASH_WORDS);
			out_err_q  <= 1'b0;
		end else if (cmd.emit_error) begin
			out_left_q <= shabh_pkg::OUT_CNT_W'(1);
			out_err_q  <= 1'b1;
		end else if (out_take) begin
			out_left_q <= out_left_q - 1'b1;
		end
	end

endmodule

// ===== src/sha256_block_hasher_core.sv =====
// SHA-256 hasher over a stream of big-endian 32-bit message words.
// Input channel s_axis: one message word per request, tlast on the final word.
// Every 16 words form a 512-bit block. A final word that completes a block
// adds the standard padding block (0x80, zeros, bit length = blocks * 512);
// the core then returns eight digest words, H0 first, tlast on H7.
// A final word that does not close a block returns one error result:
// tdata zero, tlast high, tuser high; the partial message is dropped.
// Sequencing: the word that closes a block holds the input off while the 64
// rounds run on the single round unit and the chaining add follows; only then
// is the next word taken. After the final word the padding block is
// compressed the same way before the digest is handed to the output buffer.
// Output channel m_axis: an eight-word buffer separates the sides; a stall
// there holds the digest, and the next message is hashed meanwhile. Only the
// hand-over of the next result waits for the buffer to drain.
// Reset (arst_n low): initial hash values, zero counts, empty output buffer.
// No clearing pass is needed; the core is ready as soon as reset is released.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_block_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	// request input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] message_word
	input  logic        s_axis_tlast,   // end_of_message
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic        m_axis_tlast,   // digest_done
	output logic        m_axis_tuser    // [0] misaligned
);

	shabh_pkg::cmd_t    cmd;
	shabh_pkg::status_t status;

	// sequencer: word count, round count, message/padding flow
	shabh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tlast  (s_axis_tlast),
		.status        (status),
		.cmd           (cmd)
	);

	// schedule window, round unit, chaining value and output buffer
	shabh_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// no request taken while the round unit is busy
	`ASSERT_IMPLIES(a_no_accept_in_round, cmd.round, !s_axis_tready, "request accepted mid-compression")
	// a result is loaded only into an empty output buffer
	`ASSERT_IMPLIES(a_emit_into_empty, cmd.emit_digest || cmd.emit_error, !status.out_busy, "result overwrote buffer")
	// an error result is always a single, closing item
	`ASSERT_IMPLIES(a_error_single, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error result without tlast")
	// a digest hand-over shows a valid non-error word next cycle
	`ASSERT_NEXT(a_digest_shown, cmd.emit_digest, m_axis_tvalid && !m_axis_tuser && !m_axis_tlast, "digest not presented")

endmodule
